/* hdl/wmvg_pkg.sv */
// Package for the wedge mesh vertex generator.
// Holds the shared sizes, operation codes, the transaction side-band record and
// the CORDIC arctangent table. No dependencies.
package wmvg_pkg;

  localparam int ANGLE_STEPS       = 6;
  localparam int CORDIC_ITERATIONS = 14;

  localparam int DEN       = ANGLE_STEPS - 1;
  localparam int DEN2      = 2 * DEN;
  localparam int NUM_W     = $clog2(DEN2 + 1);
  localparam int K_W       = $clog2(ANGLE_STEPS);
  localparam int N_W       = 16 + NUM_W;
  localparam int RSHIFT    = N_W + 1;
  localparam int RECIP_W   = RSHIFT + 1;
  localparam int RECIP     = (2 ** RSHIFT) / DEN2;
  localparam int PADD_PT   = 2 * (DEN / 2);

  localparam int XW        = 33;
  localparam int ZW        = 26;
  localparam int CORDIC_GAIN_INV = 652032874;
  localparam int Q14_ONE   = 16384;

  localparam logic [2:0] OP_POINT = 3'd0;
  localparam logic [2:0] OP_NEG   = 3'd1;
  localparam logic [2:0] OP_POS   = 3'd2;
  localparam logic [2:0] OP_ZP    = 3'd3;
  localparam logic [2:0] OP_ZN    = 3'd4;
  localparam logic [2:0] OP_CS    = 3'd5;
  localparam logic [2:0] OP_CE    = 3'd6;

  typedef struct packed {
    logic [2:0]         op;
    logic [4:0]         idx;
    logic [15:0]        radius;
    logic signed [16:0] zc;
    logic               last;
  } meta_t;

  function automatic logic [ZW-1:0] atan_lut(input int i);
    logic [ZW-1:0] v;
    case (i)
      0:  v = ZW'(2097152);
      1:  v = ZW'(1238021);
      2:  v = ZW'(654136);
      3:  v = ZW'(332050);
      4:  v = ZW'(166669);
      5:  v = ZW'(83416);
      6:  v = ZW'(41718);
      7:  v = ZW'(20860);
      8:  v = ZW'(10430);
      9:  v = ZW'(5215);
      10: v = ZW'(2608);
      11: v = ZW'(1304);
      12: v = ZW'(652);
      13: v = ZW'(326);
      14: v = ZW'(163);
      default: v = ZW'(81);
    endcase
    return v;
  endfunction

endpackage

/* hdl/wedge_mesh_vertex_generator_top.sv */
// Top level of the wedge mesh vertex generator.
// Depends on wmvg_pkg, wmvg_seq, wmvg_angle, wmvg_cordic and wmvg_out.
//
// One request on the slave stream describes an annular wedge; the block
// answers on the master stream with 24 mesh points and, when smooth_draw is
// 0, 14 face normals after them. The final transaction of a request carries
// tlast; tuser is 0 for a point and 1 for a normal.
// Results leave at one per cycle while the master side takes them, so a
// request occupies the sequencer for 24 or 38 result slots, and the next request is taken in the
// same cycle as the previous one's last slot is issued, so requests follow with no gap. Between
// an accepted request and its first result lie, with CORDIC_ITERATIONS at 14,
// three angle stages, a fold stage, one stage per
// CORDIC iteration, a rounding stage, a multiply stage and the output register.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so a stall on the master side holds every stage
// and loses nothing. smooth_draw is written through cfg_we and cfg_wdata,
// resets to 1 and is sampled when a request is accepted.
// Reset empties the pipeline and the sequencer.
module wedge_mesh_vertex_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // inner_radius[15:0], outer_radius[31:16], half_length[47:32],
  // start_angle[63:48], sweep_angle[79:64]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // item_index[4:0], coord_x[21:5], coord_y[38:22], coord_z[55:39]
  output logic [55:0] m_axis_tdata,
  // item_kind[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import wmvg_pkg::*;

  logic               smooth_draw;
  logic               en;
  logic               sq_v, an_v, co_v;
  meta_t              sq_m, an_m, co_m;
  logic [NUM_W-1:0]   num, padd;
  logic [15:0]        start, sweep, angle;
  logic signed [15:0] cs, sn;

  assign en = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_draw <= 1'b1;
    end else if (cfg_we) begin
      smooth_draw <= cfg_wdata;
    end
  end

  wmvg_seq u_seq (
    .clk, .rst, .en, .smooth_draw,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .issue(sq_v), .meta(sq_m), .num, .padd, .start, .sweep
  );

  wmvg_angle u_angle (
    .clk, .rst, .en, .in_valid(sq_v), .in_meta(sq_m), .num, .padd, .start, .sweep,
    .out_valid(an_v), .out_meta(an_m), .angle
  );

  wmvg_cordic u_cordic (
    .clk, .rst, .en, .in_valid(an_v), .in_meta(an_m), .angle,
    .out_valid(co_v), .out_meta(co_m), .cs, .sn
  );

  wmvg_out u_out (
    .clk, .rst, .en, .in_valid(co_v), .in_meta(co_m), .cs, .sn,
    .out_valid(m_axis_tvalid), .out_data(m_axis_tdata),
    .out_kind(m_axis_tuser), .out_last(m_axis_tlast)
  );

endmodule

/* hdl/wmvg_seq.sv */
// Request sequencer: holds one request and issues one result slot per cycle while en is high.
// Depends on wmvg_pkg.
module wmvg_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        smooth_draw,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [79:0]                 in_data,
  output logic                        issue,
  output wmvg_pkg::meta_t             meta,
  output logic [wmvg_pkg::NUM_W-1:0]  num,
  output logic [wmvg_pkg::NUM_W-1:0]  padd,
  output logic [15:0]                 start,
  output logic [15:0]                 sweep
);
  import wmvg_pkg::*;

  localparam logic [3:0] PH_IT = 4'd0;
  localparam logic [3:0] PH_IB = 4'd1;
  localparam logic [3:0] PH_OT = 4'd2;
  localparam logic [3:0] PH_OB = 4'd3;
  localparam logic [3:0] PH_NI = 4'd4;
  localparam logic [3:0] PH_NO = 4'd5;
  localparam logic [3:0] PH_ZP = 4'd6;
  localparam logic [3:0] PH_ZN = 4'd7;
  localparam logic [3:0] PH_CS = 4'd8;
  localparam logic [3:0] PH_CE = 4'd9;

  logic             busy;
  logic [3:0]       phase;
  logic [K_W-1:0]   k;
  logic [4:0]       idx;
  logic             smooth;
  logic [15:0]      rin, rout, hl;
  logic             last_now;
  logic             kend_pt, kend_nm;
  logic [NUM_W-1:0] k2;

  assign kend_pt  = (k == K_W'(ANGLE_STEPS - 1));
  assign kend_nm  = (k == K_W'(ANGLE_STEPS - 2));
  assign last_now = ((phase == PH_OB) && kend_pt && smooth) || (phase == PH_CE);
  assign issue    = busy && en;
  assign in_ready = en && (!busy || last_now);
  assign k2       = NUM_W'({k, 1'b0});

  always_comb begin
    meta.idx  = idx;
    meta.last = last_now;
    meta.radius = rin;
    meta.zc   = 17'sd0;
    meta.op   = OP_POINT;
    num       = k2;
    padd      = NUM_W'(DEN);
    unique case (phase)
      PH_IT: begin meta.zc = $signed({1'b0, hl}); padd = NUM_W'(PADD_PT); end
      PH_IB: begin meta.zc = -$signed({1'b0, hl}); padd = NUM_W'(PADD_PT); end
      PH_OT: begin
        meta.zc = $signed({1'b0, hl}); meta.radius = rout; padd = NUM_W'(PADD_PT);
      end
      PH_OB: begin
        meta.zc = -$signed({1'b0, hl}); meta.radius = rout; padd = NUM_W'(PADD_PT);
      end
      PH_NI: begin meta.op = OP_NEG; num = k2 | NUM_W'(1); end
      PH_NO: begin meta.op = OP_POS; num = k2 | NUM_W'(1); end
      PH_ZP: meta.op = OP_ZP;
      PH_ZN: meta.op = OP_ZN;
      PH_CS: begin meta.op = OP_CS; num = '0; end
      PH_CE: begin meta.op = OP_CE; num = NUM_W'(DEN2); end
      default: meta.op = OP_POINT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (en) begin
      if (in_valid && in_ready) begin
        busy   <= 1'b1;
        phase  <= PH_IT;
        k      <= '0;
        idx    <= '0;
        smooth <= smooth_draw;
        rin    <= in_data[15:0];
        rout   <= in_data[31:16];
        hl     <= in_data[47:32];
        start  <= in_data[63:48];
        sweep  <= in_data[79:64];
      end else if (busy) begin
        if ((phase == PH_OB) && kend_pt) begin
          idx <= '0;
        end else begin
          idx <= idx + 5'd1;
        end
        if (last_now) begin
          busy <= 1'b0;
        end else if (phase <= PH_OB) begin
          if (kend_pt) begin
            k <= '0;
            phase <= phase + 4'd1;
          end else begin
            k <= k + K_W'(1);
          end
        end else if (phase <= PH_NO) begin
          if (kend_nm) begin
            k <= '0;
            phase <= phase + 4'd1;
          end else begin
            k <= k + K_W'(1);
          end
        end else begin
          phase <= phase + 4'd1;
        end
      end
    end
  end

endmodule

/* hdl/wmvg_angle.sv */
// Angle stages: start + round(sweep * num / DEN2) by reciprocal multiplication.
// Depends on wmvg_pkg.
module wmvg_angle (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  wmvg_pkg::meta_t            in_meta,
  input  logic [wmvg_pkg::NUM_W-1:0] num,
  input  logic [wmvg_pkg::NUM_W-1:0] padd,
  input  logic [15:0]                start,
  input  logic [15:0]                sweep,
  output logic                       out_valid,
  output wmvg_pkg::meta_t            out_meta,
  output logic [15:0]                angle
);
  import wmvg_pkg::*;

  logic                     v1, v2;
  meta_t                    m1, m2;
  logic [15:0]              st1, st2;
  logic [N_W-1:0]           n1, n2;
  logic [15:0]              q2;
  logic [N_W+RECIP_W-1:0]   prod;
  logic [N_W-1:0]           rem;
  logic [15:0]              q;

  assign prod = {{RECIP_W{1'b0}}, n1} * (N_W+RECIP_W)'(RECIP);
  assign rem  = n2 - N_W'(q2 * N_W'(DEN2));
  assign q    = (rem >= N_W'(DEN2)) ? q2 + 16'd1 : q2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1  <= in_meta;
      st1 <= start;
      n1  <= N_W'(sweep) * N_W'(num) + N_W'(padd);
      m2  <= m1;
      st2 <= st1;
      n2  <= n1;
      q2  <= prod[RSHIFT +: 16];
      out_meta <= m2;
      angle    <= st2 + q;
    end
  end

endmodule

/* hdl/wmvg_cordic.sv */
// Pipelined rotation CORDIC, one iteration per stage, Q1.14 cosine and sine out.
// Depends on wmvg_pkg.
module wmvg_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  wmvg_pkg::meta_t     in_meta,
  input  logic [15:0]         angle,
  output logic                out_valid,
  output wmvg_pkg::meta_t     out_meta,
  output logic signed [15:0]  cs,
  output logic signed [15:0]  sn
);
  import wmvg_pkg::*;

  localparam int NI = CORDIC_ITERATIONS;

  logic                 v [NI+1];
  meta_t                m [NI+1];
  logic                 fl [NI+1];
  logic signed [XW-1:0] x [NI+1];
  logic signed [XW-1:0] y [NI+1];
  logic signed [ZW-1:0] z [NI+1];

  logic        fold;
  logic [15:0] a;

  assign fold = (angle >= 16'h4000) && (angle < 16'hC000);
  assign a    = fold ? angle - 16'h8000 : angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0]  <= in_meta;
      fl[0] <= fold;
      x[0]  <= XW'(CORDIC_GAIN_INV);
      y[0]  <= '0;
      z[0]  <= $signed({{(ZW-24){a[15]}}, a, 8'h00});
    end
  end

  for (genvar i = 0; i < NI; i++) begin : g_iter
    logic signed [XW-1:0] dx, dy;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        m[i+1]  <= m[i];
        fl[i+1] <= fl[i];
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - $signed(atan_lut(i));
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + $signed(atan_lut(i));
        end
      end
    end
  end

  logic signed [XW-1:0]  xr, yr;
  logic signed [XW-17:0] cr, sr;
  logic signed [15:0]    cc, sc;

  assign xr = (x[NI] + XW'(32768)) >>> 16;
  assign yr = (y[NI] + XW'(32768)) >>> 16;
  assign cr = xr[XW-17:0];
  assign sr = yr[XW-17:0];

  always_comb begin
    if (cr > (XW-16)'(Q14_ONE)) begin
      cc = 16'(Q14_ONE);
    end else if (cr < -(XW-16)'(Q14_ONE)) begin
      cc = -16'(Q14_ONE);
    end else begin
      cc = cr[15:0];
    end
    if (sr > (XW-16)'(Q14_ONE)) begin
      sc = 16'(Q14_ONE);
    end else if (sr < -(XW-16)'(Q14_ONE)) begin
      sc = -16'(Q14_ONE);
    end else begin
      sc = sr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[NI];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_meta <= m[NI];
      cs <= fl[NI] ? -cc : cc;
      sn <= fl[NI] ? -sc : sc;
    end
  end

endmodule

/* hdl/wmvg_out.sv */
// Scaling multiply, rounding and result assembly into the output register.
// Depends on wmvg_pkg.
module wmvg_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  wmvg_pkg::meta_t    in_meta,
  input  logic signed [15:0] cs,
  input  logic signed [15:0] sn,
  output logic               out_valid,
  output logic [55:0]        out_data,
  output logic               out_kind,
  output logic               out_last
);
  import wmvg_pkg::*;

  logic               v1;
  meta_t              m1;
  logic signed [15:0] c1, s1;
  logic signed [32:0] px, py, rx, ry;
  logic signed [16:0] ox, oy, oz, ce, se;

  assign rx = (px + 33'sd8192) >>> 14;
  assign ry = (py + 33'sd8192) >>> 14;
  assign ce = 17'(c1);
  assign se = 17'(s1);

  always_comb begin
    ox = '0;
    oy = '0;
    oz = '0;
    case (m1.op)
      OP_POINT: begin ox = rx[16:0]; oy = ry[16:0]; oz = m1.zc; end
      OP_NEG:   begin ox = -ce; oy = -se; end
      OP_POS:   begin ox = ce; oy = se; end
      OP_ZP:    oz = 17'(Q14_ONE);
      OP_ZN:    oz = -17'(Q14_ONE);
      OP_CS:    begin ox = se; oy = -ce; end
      OP_CE:    begin ox = -se; oy = ce; end
      default:  oz = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= in_meta;
      c1 <= cs;
      s1 <= sn;
      px <= $signed({1'b0, in_meta.radius}) * cs;
      py <= $signed({1'b0, in_meta.radius}) * sn;
      out_data <= {oz, oy, ox, m1.idx};
      out_kind <= (m1.op != OP_POINT);
      out_last <= m1.last;
    end
  end

endmodule
